// ----- rtl/core/fpt_pkg.sv -----
// Package for the field path tokenizer: channel payload types, result kinds
// and the per-byte result batch. No dependencies.
`default_nettype none

package fpt_pkg;

	localparam int unsigned BATCH_MAX   = 3;
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W      = 2;
	localparam int unsigned QCNT_W      = 3;

	localparam logic [2:0] KIND_KEY_BYTE  = 3'd0;
	localparam logic [2:0] KIND_KEY_END   = 3'd1;
	localparam logic [2:0] KIND_INDEX_END = 3'd2;
	localparam logic [2:0] KIND_ACCEPT    = 3'd3;
	localparam logic [2:0] KIND_REJECT    = 3'd4;

	typedef struct packed {
		logic [7:0] char_in;
		logic       last_char;
	} fpt_in_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  key_byte;
		logic [15:0] index_value;
		logic [5:0]  segment_total;
		logic        last_result;
	} fpt_out_t;

	typedef struct packed {
		logic [1:0]                   count;
		fpt_out_t [BATCH_MAX-1:0]     item;
	} fpt_batch_t;

endpackage

`default_nettype wire

// ----- rtl/core/fpt_parse_core.sv -----
// Path parsing state machine: turns the registered byte into a batch of up
// to three results and updates the parse state on advance. Uses fpt_pkg.
`default_nettype none

module fpt_parse_core #(
	parameter int unsigned     MAX_DEPTH = 32,
	parameter longint unsigned MAX_INDEX = 65535
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire fpt_pkg::fpt_in_t   item_s1,
	input  wire logic               advance,
	output fpt_pkg::fpt_batch_t     batch
);
	import fpt_pkg::*;

	localparam int unsigned SEG_W = $clog2(MAX_DEPTH + 1);
	localparam int unsigned IDX_W = $clog2(MAX_INDEX + 2);
	localparam logic [IDX_W-1:0]   IDX_SAT   = IDX_W'(MAX_INDEX + 1);
	localparam logic [IDX_W+3:0]   IDX_LIMIT = (IDX_W + 4)'(MAX_INDEX);
	localparam logic [SEG_W-1:0]   DEPTH_LIM = SEG_W'(MAX_DEPTH);
	localparam logic [SEG_W:0]     DEPTH_LIM1 = (SEG_W + 1)'(MAX_DEPTH);

	typedef enum logic [10:0] {
		PH_START   = 11'b000_0000_0001,
		PH_AFTROOT = 11'b000_0000_0010,
		PH_AFTDOT  = 11'b000_0000_0100,
		PH_IDENT   = 11'b000_0000_1000,
		PH_SEGDONE = 11'b000_0001_0000,
		PH_BROPEN  = 11'b000_0010_0000,
		PH_QKEY    = 11'b000_0100_0000,
		PH_QESC    = 11'b000_1000_0000,
		PH_QCLOSE  = 11'b001_0000_0000,
		PH_INDEX   = 11'b010_0000_0000,
		PH_DEAD    = 11'b100_0000_0000
	} phase_t;

	phase_t           phase_q, phase_d;
	logic [SEG_W-1:0] seg_q, seg_d;
	logic [IDX_W-1:0] acc_q, acc_d;
	logic             big_q, big_d;
	logic             fz_q, fz_d;

	logic [7:0]       c;
	logic             is_digit, is_first, is_more, full, full_next;
	logic [3:0]       digit_val;
	logic [IDX_W+3:0] prod;
	logic             bad, has_main, has_end, ok;
	logic [2:0]       main_kind;
	logic [7:0]       main_byte;
	logic [IDX_W+15:0] idx_ext;
	logic [SEG_W+5:0] seg_main_ext, seg_end_ext;
	logic [SEG_W-1:0] seg_fin;
	fpt_out_t         main_r, end_r, verdict_r;
	logic [1:0]       n;

	function automatic logic id_first(input logic [7:0] ch);
		return (ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z") || ch == "_";
	endfunction

	assign c         = item_s1.char_in;
	assign is_digit  = (c >= "0") && (c <= "9");
	assign is_first  = id_first(c);
	assign is_more   = is_first || is_digit || c == "-";
	assign digit_val = 4'(c - "0");
	assign full      = seg_q >= DEPTH_LIM;
	assign full_next = ({1'b0, seg_q} + 1'b1) >= DEPTH_LIM1;
	assign prod      = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} +
		{{IDX_W{1'b0}}, digit_val};

	always_comb begin
		phase_d   = phase_q;
		seg_d     = seg_q;
		acc_d     = acc_q;
		big_d     = big_q;
		fz_d      = fz_q;
		bad       = 1'b0;
		has_main  = 1'b0;
		main_kind = KIND_KEY_BYTE;
		main_byte = 8'd0;
		unique case (phase_q)
			PH_START: begin
				if (c == ".") phase_d = PH_AFTROOT;
				else bad = 1'b1;
			end
			PH_AFTROOT, PH_AFTDOT: begin
				if (c == "[") begin
					if (phase_q == PH_AFTROOT && full) bad = 1'b1;
					else phase_d = PH_BROPEN;
				end else if (is_first) begin
					if (phase_q == PH_AFTROOT && full) begin
						bad = 1'b1;
					end else begin
						has_main  = 1'b1;
						main_byte = c;
						phase_d   = PH_IDENT;
					end
				end else begin
					bad = 1'b1;
				end
			end
			PH_IDENT: begin
				if (is_more) begin
					has_main  = 1'b1;
					main_byte = c;
				end else if (c == "." || c == "[") begin
					if (full_next) begin
						bad = 1'b1;
					end else begin
						seg_d     = seg_q + 1'b1;
						has_main  = 1'b1;
						main_kind = KIND_KEY_END;
						phase_d   = (c == ".") ? PH_AFTDOT : PH_BROPEN;
					end
				end else begin
					bad = 1'b1;
				end
			end
			PH_SEGDONE: begin
				if ((c == "." || c == "[") && !full)
					phase_d = (c == ".") ? PH_AFTDOT : PH_BROPEN;
				else
					bad = 1'b1;
			end
			PH_BROPEN: begin
				if (c == "\"") begin
					phase_d = PH_QKEY;
				end else if (is_digit) begin
					acc_d   = IDX_W'(digit_val);
					big_d   = 1'b0;
					fz_d    = (c == "0");
					phase_d = PH_INDEX;
				end else begin
					bad = 1'b1;
				end
			end
			PH_QKEY: begin
				if (c == "\"") begin
					phase_d = PH_QCLOSE;
				end else if (c == "\\") begin
					phase_d = PH_QESC;
				end else begin
					has_main  = 1'b1;
					main_byte = c;
				end
			end
			PH_QESC: begin
				if (c == "\"" || c == "\\") begin
					has_main  = 1'b1;
					main_byte = c;
					phase_d   = PH_QKEY;
				end else begin
					bad = 1'b1;
				end
			end
			PH_QCLOSE: begin
				if (c == "]") begin
					seg_d     = seg_q + 1'b1;
					has_main  = 1'b1;
					main_kind = KIND_KEY_END;
					phase_d   = PH_SEGDONE;
				end else begin
					bad = 1'b1;
				end
			end
			PH_INDEX: begin
				if (is_digit) begin
					if (fz_q) begin
						bad = 1'b1;
					end else if (prod > IDX_LIMIT) begin
						big_d = 1'b1;
						acc_d = IDX_SAT;
					end else begin
						acc_d = IDX_W'(prod);
					end
				end else if (c == "]" && !big_q) begin
					seg_d     = seg_q + 1'b1;
					has_main  = 1'b1;
					main_kind = KIND_INDEX_END;
					phase_d   = PH_SEGDONE;
				end else begin
					bad = 1'b1;
				end
			end
			default: begin
				bad = 1'b1;
			end
		endcase

		if (bad) begin
			has_main = 1'b0;
			phase_d  = PH_DEAD;
		end

		has_end = item_s1.last_char && (phase_d == PH_IDENT);
		ok      = has_end || phase_d == PH_SEGDONE || phase_d == PH_AFTROOT;
		seg_fin = has_end ? seg_d + 1'b1 : seg_d;

		if (item_s1.last_char) begin
			phase_d = PH_START;
			seg_d   = '0;
			acc_d   = '0;
			big_d   = 1'b0;
			fz_d    = 1'b0;
		end
	end

	assign idx_ext      = {16'd0, acc_q};
	assign seg_main_ext = {6'd0, (item_s1.last_char && has_end) ? seg_fin - 1'b1 : seg_fin};
	assign seg_end_ext  = {6'd0, seg_fin};

	always_comb begin
		main_r             = '0;
		main_r.kind        = main_kind;
		main_r.key_byte    = (main_kind == KIND_KEY_BYTE) ? main_byte : 8'd0;
		main_r.index_value = (main_kind == KIND_INDEX_END) ? idx_ext[15:0] : 16'd0;
		main_r.segment_total = seg_main_ext[5:0];

		end_r               = '0;
		end_r.kind          = KIND_KEY_END;
		end_r.segment_total = seg_end_ext[5:0];

		verdict_r               = '0;
		verdict_r.kind          = ok ? KIND_ACCEPT : KIND_REJECT;
		verdict_r.segment_total = seg_end_ext[5:0];

		batch = '0;
		n     = 2'd0;
		if (has_main) begin
			batch.item[n] = main_r;
			n             = n + 2'd1;
		end
		if (has_end) begin
			batch.item[n] = end_r;
			n             = n + 2'd1;
		end
		if (item_s1.last_char) begin
			batch.item[n] = verdict_r;
			n             = n + 2'd1;
		end
		if (n != 2'd0) batch.item[n - 2'd1].last_result = 1'b1;
		batch.count = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			seg_q   <= '0;
			acc_q   <= '0;
			big_q   <= 1'b0;
			fz_q    <= 1'b0;
		end else if (advance) begin
			phase_q <= phase_d;
			seg_q   <= seg_d;
			acc_q   <= acc_d;
			big_q   <= big_d;
			fz_q    <= fz_d;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/fpt_result_queue.sv -----
// Result queue (uses fpt_pkg): takes a batch of up to three results per
// cycle and presents one per cycle on the result channel unless stalled.
`default_nettype none

module fpt_result_queue (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        push,
	input  wire fpt_pkg::fpt_batch_t         batch,
	output logic [fpt_pkg::QCNT_W-1:0]       free,
	output logic                             result_valid,
	input  wire logic                        result_stall,
	output fpt_pkg::fpt_out_t                result
);
	import fpt_pkg::*;

	fpt_out_t          mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] head_q, tail_q;
	logic [QCNT_W-1:0] count_q;
	logic              pop;
	logic [QCNT_W-1:0] push_n;

	assign free         = QCNT_W'(QUEUE_DEPTH) - count_q;
	assign result_valid = count_q != '0;
	assign result       = mem_q[head_q];
	assign pop          = result_valid && !result_stall;
	assign push_n       = push ? QCNT_W'(batch.count) : '0;

	always_ff @(posedge clk) begin
		for (int i = 0; i < BATCH_MAX; i++) begin
			if (push && 2'(i) < batch.count)
				mem_q[tail_q + QPTR_W'(i)] <= batch.item[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (pop) head_q <= head_q + 1'b1;
			tail_q  <= tail_q + QPTR_W'(push_n);
			count_q <= count_q + push_n - QCNT_W'(pop);
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/field_path_tokenizer.sv -----
// Field path tokenizer top level: input register, parse core, result queue.
// Depends on fpt_pkg, fpt_parse_core and fpt_result_queue.
//
// Takes one path byte per cycle while item_stall is low and parses it in a
// single pass from the input register into a four-entry result queue. A
// byte that yields at most one result sustains one byte per cycle while
// result_stall is low; the result channel carries one transaction per
// cycle, so a byte that yields two or three results (key byte with end of
// path) takes one transaction per result, and the input stalls whenever
// the queue lacks room for the batch of the registered byte. A byte's first
// result is offered once the input register and the queue have taken it.
`default_nettype none

module field_path_tokenizer #(
	parameter int unsigned     MAX_DEPTH = 32,
	parameter longint unsigned MAX_INDEX = 65535
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              item_valid,
	output logic                   item_stall,
	input  wire fpt_pkg::fpt_in_t  item,
	output logic                   result_valid,
	input  wire logic              result_stall,
	output fpt_pkg::fpt_out_t      result
);
	import fpt_pkg::*;

	fpt_in_t           item_s1;
	logic              valid_s1;
	logic              advance, load;
	fpt_batch_t        batch;
	logic [QCNT_W-1:0] free;

	assign advance    = valid_s1 && ({1'b0, batch.count} <= free);
	assign item_stall = valid_s1 && !advance;
	assign load       = item_valid && !item_stall;

	always_ff @(posedge clk) begin
		if (load) item_s1 <= item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	fpt_parse_core #(
		.MAX_DEPTH(MAX_DEPTH),
		.MAX_INDEX(MAX_INDEX)
	) u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.item_s1 (item_s1),
		.advance (advance),
		.batch   (batch)
	);

	fpt_result_queue u_queue (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (advance),
		.batch        (batch),
		.free         (free),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

`default_nettype wire
